[src/vertex_rotate_project_macros.svh]
// Assertion helpers for the design file that checks its own logic.
`ifndef VERTEX_ROTATE_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_MACROS_SVH

// The condition must hold at every edge outside reset.
`define VRP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent must hold at the edge where the antecedent holds.
`define VRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[src/vrp_pkg.sv]
package vrp_pkg;

    localparam int SINE_ENTRIES = 256;
    localparam int NUM_BITS     = 27;              // magnitude bits of the numerator
    localparam int DIV_FIRST    = 8;               // first divider stage
    localparam int OUT_STAGE    = DIV_FIRST + NUM_BITS;
    localparam int NUM_STAGES   = OUT_STAGE + 1;

    typedef enum logic [2:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_FOCAL_LENGTH = 3'd2,
        REG_DEPTH_OFFSET = 3'd3,
        REG_NEAR_LIMIT   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [16:0]         rem;
        logic [NUM_BITS-1:0] quo;
    } t_div_state;

    // Parabolic sine: i*(128-i)/16, negated in the second half turn.
    function automatic logic signed [9:0] sine_rom(input logic [7:0] a);
        logic [6:0]  i;
        logic [7:0]  c;
        logic [14:0] p;
        logic [9:0]  v;
        i = a[6:0];
        c = 8'd128 - {1'b0, i};
        p = {8'd0, i} * {7'd0, c};
        v = {1'b0, p[12:4]};
        sine_rom = a[7] ? -$signed(v) : $signed(v);
    endfunction

    // One restoring division step.
    function automatic t_div_state div_step(input t_div_state s, input logic [16:0] d);
        logic [17:0] t;
        t_div_state  r;
        t = {s.rem, s.quo[NUM_BITS-1]};
        if (t >= {1'b0, d}) begin
            r.rem = 17'(t - {1'b0, d});
            r.quo = {s.quo[NUM_BITS-2:0], 1'b1};
        end else begin
            r.rem = t[16:0];
            r.quo = {s.quo[NUM_BITS-2:0], 1'b0};
        end
        div_step = r;
    endfunction

endpackage

[src/vertex_rotate_project.sv]
// Throughput: one word per cycle unless the output stalls; a stage holds its word while the next cannot take it.
// The two perspective divisions run as 27 restoring steps, one stage per bit.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: center 160/112, focal 200, depth offset 256, near limit 16.
`include "vertex_rotate_project_macros.svh"

module vertex_rotate_project (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_vert_x,
    input  logic signed [15:0] i_vert_y,
    input  logic signed [15:0] i_vert_z,
    input  logic [7:0]         i_angle_x,
    input  logic [7:0]         i_angle_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic [16:0]        o_depth
);
    import vrp_pkg::*;

    logic [9:0]  r_center_x, r_center_y, r_focal;
    logic [11:0] r_offset, r_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= 10'd160;
            r_center_y <= 10'd112;
            r_focal    <= 10'd200;
            r_offset   <= 12'd256;
            r_near     <= 12'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:     r_center_x <= i_cfg_data[9:0];
                REG_CENTER_Y:     r_center_y <= i_cfg_data[9:0];
                REG_FOCAL_LENGTH: r_focal    <= i_cfg_data[9:0];
                REG_DEPTH_OFFSET: r_offset   <= i_cfg_data;
                REG_NEAR_LIMIT:   r_near     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-stage load enables: a stage loads when empty or when its word moves on.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: input capture and sine lookups.
    logic signed [15:0] r0_x, r0_y, r0_z;
    logic signed [9:0]  r0_sx, r0_cx, r0_sy, r0_cy;
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_x  <= i_vert_x;
            r0_y  <= i_vert_y;
            r0_z  <= i_vert_z;
            r0_sx <= sine_rom(i_angle_x);
            r0_cx <= sine_rom(8'(i_angle_x + 8'(SINE_ENTRIES / 4)));
            r0_sy <= sine_rom(i_angle_y);
            r0_cy <= sine_rom(8'(i_angle_y + 8'(SINE_ENTRIES / 4)));
        end
    end

    // Stage 1: products of the rotation about Y.
    logic signed [25:0] r1_p0, r1_p1, r1_p2, r1_p3;
    logic signed [15:0] r1_y;
    logic signed [9:0]  r1_sx, r1_cx;
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_p0 <= r0_x * r0_cy;
            r1_p1 <= r0_z * r0_sy;
            r1_p2 <= r0_x * r0_sy;
            r1_p3 <= r0_z * r0_cy;
            r1_y  <= r0_y;
            r1_sx <= r0_sx;
            r1_cx <= r0_cx;
        end
    end

    // Stage 2: sums of the rotation about Y; results fit 18 bits.
    logic signed [26:0] s2_a, s2_b;
    logic signed [17:0] r2_x, r2_z;
    logic signed [15:0] r2_y;
    logic signed [9:0]  r2_sx, r2_cx;
    assign s2_a = 27'(r1_p0) - 27'(r1_p1);
    assign s2_b = 27'(r1_p2) + 27'(r1_p3);
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_x  <= s2_a[25:8];
            r2_z  <= s2_b[25:8];
            r2_y  <= r1_y;
            r2_sx <= r1_sx;
            r2_cx <= r1_cx;
        end
    end

    // Stage 3: products of the rotation about X.
    logic signed [25:0] r3_p0, r3_p2;
    logic signed [27:0] r3_p1, r3_p3;
    logic signed [17:0] r3_x;
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_p0 <= r2_y * r2_cx;
            r3_p1 <= r2_z * r2_sx;
            r3_p2 <= r2_y * r2_sx;
            r3_p3 <= r2_z * r2_cx;
            r3_x  <= r2_x;
        end
    end

    // Stage 4: sums of the rotation about X.
    logic signed [28:0] s4_a, s4_b;
    logic signed [17:0] r4_x, r4_y, r4_z;
    assign s4_a = 29'(r3_p0) - 29'(r3_p1);
    assign s4_b = 29'(r3_p2) + 29'(r3_p3);
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_x <= r3_x;
            r4_y <= s4_a[25:8];
            r4_z <= s4_b[25:8];
        end
    end

    // Stage 5: depth offset and near clamp; a near limit of zero acts as one.
    logic signed [18:0] s5_z, s5_lim;
    logic signed [17:0] r5_x, r5_y;
    logic [16:0]        r5_d;
    assign s5_z   = 19'(r4_z) + $signed({7'd0, r_offset});
    assign s5_lim = (r_near == '0) ? 19'sd1 : $signed({7'd0, r_near});
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_x <= r4_x;
            r5_y <= r4_y;
            r5_d <= (s5_z < s5_lim) ? s5_lim[16:0] : s5_z[16:0];
        end
    end

    // Stage 6: perspective numerators.
    logic signed [28:0] r6_nx, r6_ny;
    logic [16:0]        r6_d;
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_nx <= r5_x * $signed({1'b0, r_focal});
            r6_ny <= r5_y * $signed({1'b0, r_focal});
            r6_d  <= r5_d;
        end
    end

    // Stage 7: sign and magnitude for the unsigned dividers.
    logic signed [28:0]  s7_mx, s7_my;
    logic [NUM_BITS-1:0] r7_mx, r7_my;
    logic                r7_negx, r7_negy;
    logic [16:0]         r7_d;
    assign s7_mx = r6_nx[28] ? -r6_nx : r6_nx;
    assign s7_my = r6_ny[28] ? -r6_ny : r6_ny;
    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r7_mx   <= s7_mx[NUM_BITS-1:0];
            r7_my   <= s7_my[NUM_BITS-1:0];
            r7_negx <= r6_nx[28];
            r7_negy <= r6_ny[28];
            r7_d    <= r6_d;
        end
    end

    // Divider stages: one quotient bit per stage for each coordinate.
    t_div_state  r_dx   [NUM_BITS];
    t_div_state  r_dy   [NUM_BITS];
    logic [16:0] r_dd   [NUM_BITS];
    logic        r_dnx  [NUM_BITS];
    logic        r_dny  [NUM_BITS];
    t_div_state  src_x  [NUM_BITS];
    t_div_state  src_y  [NUM_BITS];
    logic [16:0] src_d  [NUM_BITS];
    logic        src_nx [NUM_BITS];
    logic        src_ny [NUM_BITS];

    always_comb begin
        src_x[0]  = '{rem: '0, quo: r7_mx};
        src_y[0]  = '{rem: '0, quo: r7_my};
        src_d[0]  = r7_d;
        src_nx[0] = r7_negx;
        src_ny[0] = r7_negy;
        for (int j = 1; j < NUM_BITS; j++) begin
            src_x[j]  = r_dx[j-1];
            src_y[j]  = r_dy[j-1];
            src_d[j]  = r_dd[j-1];
            src_nx[j] = r_dnx[j-1];
            src_ny[j] = r_dny[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_BITS; j++) begin
            if (en[DIV_FIRST + j]) begin
                r_dx[j]  <= div_step(src_x[j], src_d[j]);
                r_dy[j]  <= div_step(src_y[j], src_d[j]);
                r_dd[j]  <= src_d[j];
                r_dnx[j] <= src_nx[j];
                r_dny[j] <= src_ny[j];
            end
        end
    end

    // Output stage: restore sign, add the center, wrap to 16 bits.
    logic [15:0] s_qx, s_qy;
    logic [15:0] r_ox, r_oy;
    logic [16:0] r_od;
    assign s_qx = r_dnx[NUM_BITS-1] ? 16'(-r_dx[NUM_BITS-1].quo[15:0])
                                    : r_dx[NUM_BITS-1].quo[15:0];
    assign s_qy = r_dny[NUM_BITS-1] ? 16'(-r_dy[NUM_BITS-1].quo[15:0])
                                    : r_dy[NUM_BITS-1].quo[15:0];
    always_ff @(posedge i_clk) begin
        if (en[OUT_STAGE]) begin
            r_ox <= 16'({6'd0, r_center_x} + s_qx);
            r_oy <= 16'({6'd0, r_center_y} + s_qy);
            r_od <= r_dd[NUM_BITS-1];
        end
    end

    assign o_valid    = r_vld[OUT_STAGE];
    assign o_screen_x = $signed(r_ox);
    assign o_screen_y = $signed(r_oy);
    assign o_depth    = r_od;

    `VRP_ASSERT_IMPL(a_depth_nonzero, i_clk, i_rst_n, o_valid, o_depth != 17'd0)
    `VRP_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_ready, r_vld[0])
    `VRP_ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_vld[OUT_STAGE-1],
        (r_dx[NUM_BITS-1].rem < r_dd[NUM_BITS-1]) && (r_dy[NUM_BITS-1].rem < r_dd[NUM_BITS-1]))

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import vrp_pkg::*;

    localparam logic [2:0] REG_SPARE_5 = 3'd5;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [16:0]        depth;
    } t_screen_point;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [11:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_vert_x;
    logic signed [15:0] i_vert_y;
    logic signed [15:0] i_vert_z;
    logic [7:0]         i_angle_x;
    logic [7:0]         i_angle_y;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_screen_x;
    logic signed [15:0] o_screen_y;
    logic [16:0]        o_depth;

    // Shadow copy of the configuration registers.
    logic [9:0]  center_x_q;
    logic [9:0]  center_y_q;
    logic [9:0]  focal_q;
    logic [11:0] depth_off_q;
    logic [11:0] near_q;

    t_screen_point projected_points[$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;

    vertex_rotate_project dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint parabolic_sine(input logic [7:0] a);
        longint i;
        longint v;
        i = a[6:0];
        v = (i * (128 - i)) / 16;
        return a[7] ? -v : v;
    endfunction

    function automatic t_screen_point project_vertex(input logic signed [15:0] vx,
            input logic signed [15:0] vy, input logic signed [15:0] vz,
            input logic [7:0] ax, input logic [7:0] ay);
        longint x, y, z, c, s, nx, nz, lim, qx, qy;
        logic [7:0] ca;
        t_screen_point p;
        x = vx;
        y = vy;
        z = vz;
        ca = ay + 8'd64;
        c = parabolic_sine(ca);
        s = parabolic_sine(ay);
        nx = (x * c - z * s) >>> 8;
        nz = (x * s + z * c) >>> 8;
        x = nx;
        z = nz;
        ca = ax + 8'd64;
        c = parabolic_sine(ca);
        s = parabolic_sine(ax);
        y = (y * c - z * s) >>> 8;
        z = (vy * s + z * c) >>> 8;
        z = z + longint'(depth_off_q);
        lim = (near_q == 0) ? 1 : longint'(near_q);
        if (z < lim) begin
            z = lim;
        end
        qx = (x * longint'(focal_q)) / z;
        qy = (y * longint'(focal_q)) / z;
        p.sx = 16'(longint'(center_x_q) + qx);
        p.sy = 16'(longint'(center_y_q) + qy);
        p.depth = z[16:0];
        return p;
    endfunction

    task automatic send_vertex(input logic [15:0] vx, input logic [15:0] vy,
            input logic [15:0] vz, input logic [7:0] ax, input logic [7:0] ay);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_vert_x  <= vx;
        i_vert_y  <= vy;
        i_vert_z  <= vz;
        i_angle_x <= ax;
        i_angle_y <= ay;
        do @(posedge i_clk); while (!o_ready);
        projected_points.push_back(project_vertex(vx, vy, vz, ax, ay));
    endtask

    task automatic send_random_vertex();
        logic [15:0] v[3];
        for (int k = 0; k < 3; k++) begin
            v[k] = $urandom();
            if ($urandom_range(3) == 0) begin
                v[k] = 16'($signed(v[k][9:0]));
            end
        end
        send_vertex(v[0], v[1], v[2], 8'($urandom()), 8'($urandom()));
    endtask

    // Every accepted word has left once the expected queue is empty,
    // and a drain pause follows before touching the registers.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (projected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_CENTER_X:     center_x_q  = data[9:0];
            REG_CENTER_Y:     center_y_q  = data[9:0];
            REG_FOCAL_LENGTH: focal_q     = data[9:0];
            REG_DEPTH_OFFSET: depth_off_q = data;
            REG_NEAR_LIMIT:   near_q      = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_view(input logic [11:0] cx, input logic [11:0] cy,
            input logic [11:0] fl, input logic [11:0] doff, input logic [11:0] nl);
        wait_idle();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_FOCAL_LENGTH, fl);
        write_reg(REG_DEPTH_OFFSET, doff);
        write_reg(REG_NEAR_LIMIT, nl);
    endtask

    task automatic test_extreme_vertices();
        logic [15:0] corner[5];
        logic [7:0]  angle[6];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        angle  = '{8'd0, 8'd64, 8'd128, 8'd192, 8'd255, 8'd127};
        for (int k = 0; k < 6; k++) begin
            send_vertex(corner[k % 5], corner[(k + 1) % 5], corner[(k + 2) % 5],
                        angle[k], angle[5 - k]);
        end
        send_vertex(16'h8000, 16'h8000, 16'h8000, 8'd0, 8'd0);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd255, 8'd255);
        send_vertex(16'h8000, 16'h7FFF, 16'h8000, 8'd64, 8'd192);
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 8'd128, 8'd128);
    endtask

    task automatic test_register_edges();
        // Writes to unused indexes must leave every register alone.
        wait_idle();
        write_reg(REG_SPARE_5, 12'hFFF);
        write_reg(REG_SPARE_7, 12'h000);
        send_vertex(16'd100, 16'hFF9C, 16'd50, 8'd10, 8'd20);
        // Near limit of zero behaves as one; upper bits of 10-bit registers drop.
        set_view(12'hFFF, 12'hC00, 12'hFFF, 12'd0, 12'd0);
        send_vertex(16'h7FFF, 16'h8000, 16'h8000, 8'd0, 8'd0);
        send_vertex(16'h8000, 16'h7FFF, 16'h0000, 8'd64, 8'd64);
        send_vertex(16'd3, 16'hFFFD, 16'hFF00, 8'd0, 8'd0);
        set_view(12'd0, 12'd1023, 12'd0, 12'd4095, 12'd4095);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd32, 8'd96);
        set_view(12'd512, 12'd384, 12'd1023, 12'd4095, 12'd1);
        send_vertex(16'h8000, 16'h8000, 16'h7FFF, 8'd200, 8'd100);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h8000, 8'd1, 8'd129);
    endtask

    task automatic test_random_stream(input int count, input bit with_hold);
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == count / 3) begin
                hold_request = LONG_HOLD;
            end
            send_random_vertex();
        end
    endtask

    task automatic test_random_views();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 6 : 0;
            set_view(12'($urandom()), 12'($urandom()), 12'($urandom()),
                     12'($urandom()), 12'($urandom_range(4095)));
            test_random_stream(300, phase != 1);
            set_view(12'd160, 12'd112, 12'($urandom_range(1023)),
                     12'($urandom_range(300)), 12'($urandom_range(64)));
            test_random_stream(300, 1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_screen_point want;
        if (i_rst_n && o_valid && i_ready) begin
            if (projected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected word: x=%0d y=%0d depth=%0d",
                             o_screen_x, o_screen_y, o_depth);
                end
            end else begin
                want = projected_points.pop_front();
                if (o_screen_x !== want.sx || o_screen_y !== want.sy
                        || o_depth !== want.depth) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected x=%0d y=%0d depth=%0d, got x=%0d y=%0d depth=%0d",
                                 want.sx, want.sy, want.depth,
                                 o_screen_x, o_screen_y, o_depth);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        send_idle_pct = 6;
        recv_idle_pct = 61;
        hold_request  = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_CENTER_X;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_vert_x   = '0;
        i_vert_y   = '0;
        i_vert_z   = '0;
        i_angle_x  = '0;
        i_angle_y  = '0;
        center_x_q  = 10'd160;
        center_y_q  = 10'd112;
        focal_q     = 10'd200;
        depth_off_q = 12'd256;
        near_q      = 12'd16;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_vertices();
        test_register_edges();
        test_random_views();

        wait_idle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[vertex_rotate_project.f]
+incdir+src
src/vrp_pkg.sv
src/vertex_rotate_project.sv
tb/tb.sv
